[hdl/mfe_pkg.sv]
// Shared types and constants of the max-flow engine.
// Used by mfe_ctrl and max_flow_shortest_path_engine; depends on nothing.
package mfe_pkg;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    localparam logic CFG_SOURCE = 1'b0;
    localparam logic CFG_SINK   = 1'b1;

    localparam int FLOW_BITS = 26;
    localparam logic [FLOW_BITS-1:0] FLOW_MAX = '1;

    localparam logic [7:0] SOURCE_RESET = 8'd0;
    localparam logic [7:0] SINK_RESET   = 8'd255;

endpackage

[hdl/mfe_ram.sv]
// Simple dual-port synchronous RAM, one write and one read port, registered read data.
// Used by the max-flow engine for its edge, list head, vertex and queue stores.
module mfe_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/mfe_ctrl.sv]
// Sequencer of the max-flow engine: edge loading, breadth-first search and augmentation.
// Depends on mfe_pkg; drives the four mfe_ram instances of the top level.
module mfe_ctrl #(
    parameter int VERTICES = 256,
    parameter int EDGES = 1024,
    parameter int CAP_BITS = 16,
    localparam int VW = $clog2(VERTICES),
    localparam int EAW = $clog2(2 * EDGES),
    localparam int EW = EAW + 1,
    localparam int EWD = VW + CAP_BITS + EW,
    localparam int VIW = 1 + VW + EAW
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    kind,
    input  logic [7:0]                    from_vertex,
    input  logic [7:0]                    to_vertex,
    input  logic [15:0]                   capacity,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mfe_pkg::FLOW_BITS-1:0] flow_value,
    output logic                          edges_dropped,
    output logic                          head_we,
    output logic [VW-1:0]                 head_waddr,
    output logic [EW-1:0]                 head_wdata,
    output logic [VW-1:0]                 head_raddr,
    input  logic [EW-1:0]                 head_rdata,
    output logic                          edge_we,
    output logic [EAW-1:0]                edge_waddr,
    output logic [EWD-1:0]                edge_wdata,
    output logic [EAW-1:0]                edge_raddr,
    input  logic [EWD-1:0]                edge_rdata,
    output logic                          vinf_we,
    output logic [VW-1:0]                 vinf_waddr,
    output logic [VIW-1:0]                vinf_wdata,
    output logic [VW-1:0]                 vinf_raddr,
    input  logic [VIW-1:0]                vinf_rdata,
    output logic                          que_we,
    output logic [VW-1:0]                 que_waddr,
    output logic [VW-1:0]                 que_wdata,
    output logic [VW-1:0]                 que_raddr,
    input  logic [VW-1:0]                 que_rdata
);

    localparam int RES = 2 * EDGES;
    localparam int FB = mfe_pkg::FLOW_BITS;
    localparam int SW = ((CAP_BITS > FB) ? CAP_BITS : FB) + 1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_HCLR, ST_ADD0, ST_ADD1, ST_ADD2, ST_RCHK, ST_VCLR, ST_SINIT,
        ST_POP, ST_POPW, ST_HEADW, ST_EDGE, ST_EDGEW, ST_VIS,
        ST_N_RD, ST_N_RDW, ST_N_CAP, ST_A_RD, ST_A_RDW, ST_A_FWD, ST_A_REV, ST_FINISH
    } state_t;

    state_t               state_reg;
    logic [7:0]           src_reg;
    logic [7:0]           snk_reg;
    logic [VW-1:0]        u_reg;
    logic [VW-1:0]        v_reg;
    logic [CAP_BITS-1:0]  capin_reg;
    logic [EW-1:0]        cnt_reg;
    logic                 drop_reg;
    logic [VW-1:0]        ptr_reg;
    logic [VW:0]          qh_reg;
    logic [VW:0]          qt_reg;
    logic [EW-1:0]        e_reg;
    logic [EW-1:0]        nxt_reg;
    logic [CAP_BITS-1:0]  ecap_reg;
    logic [VW-1:0]        w_reg;
    logic [VW-1:0]        pred_reg;
    logic [EAW-1:0]       pe_reg;
    logic [CAP_BITS-1:0]  neck_reg;
    logic [FB-1:0]        total_reg;
    logic                 out_valid_reg;
    logic [FB-1:0]        flow_reg;
    logic                 odrop_reg;

    logic [VW-1:0]        s_v;
    logic [VW-1:0]        t_v;
    logic [VW-1:0]        e_tgt;
    logic [CAP_BITS-1:0]  e_cap;
    logic [EW-1:0]        e_nxt;
    logic                 v_vis;
    logic [VW-1:0]        v_pred;
    logic [EAW-1:0]       v_pe;
    logic [EW-1:0]        cnt_p1;
    logic                 take;
    logic                 from_ok;
    logic                 to_ok;
    logic                 store_full;
    logic [SW-1:0]        sum;

    assign s_v = VW'(src_reg);
    assign t_v = VW'(snk_reg);
    assign e_tgt = edge_rdata[EWD-1 -: VW];
    assign e_cap = edge_rdata[EW +: CAP_BITS];
    assign e_nxt = edge_rdata[EW-1:0];
    assign v_vis = vinf_rdata[VIW-1];
    assign v_pred = vinf_rdata[EAW +: VW];
    assign v_pe = vinf_rdata[EAW-1:0];
    assign cnt_p1 = cnt_reg + EW'(1);
    assign take = !v_vis && (ecap_reg != '0);
    assign from_ok = 32'(from_vertex) < 32'(VERTICES);
    assign to_ok = 32'(to_vertex) < 32'(VERTICES);
    assign store_full = (32'(cnt_reg) + 32'd2) > 32'(RES);
    assign sum = SW'(total_reg) + SW'(neck_reg);

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign flow_value = flow_reg;
    assign edges_dropped = odrop_reg;

    always_comb
    begin
        head_we = 1'b0;
        head_waddr = '0;
        head_wdata = '0;
        head_raddr = '0;
        edge_we = 1'b0;
        edge_waddr = '0;
        edge_wdata = '0;
        edge_raddr = '0;
        vinf_we = 1'b0;
        vinf_waddr = '0;
        vinf_wdata = '0;
        vinf_raddr = '0;
        que_we = 1'b0;
        que_waddr = '0;
        que_wdata = '0;
        que_raddr = '0;
        unique case (state_reg)
            ST_HCLR:
            begin
                head_we = 1'b1;
                head_waddr = ptr_reg;
                head_wdata = '1;
            end
            ST_ADD0:
            begin
                head_raddr = u_reg;
            end
            ST_ADD1:
            begin
                edge_we = 1'b1;
                edge_waddr = cnt_reg[EAW-1:0];
                edge_wdata = {v_reg, capin_reg, head_rdata};
                head_we = 1'b1;
                head_waddr = u_reg;
                head_wdata = cnt_reg;
                head_raddr = v_reg;
            end
            ST_ADD2:
            begin
                edge_we = 1'b1;
                edge_waddr = cnt_p1[EAW-1:0];
                edge_wdata = {u_reg, {CAP_BITS{1'b0}}, (v_reg == u_reg) ? cnt_reg : head_rdata};
                head_we = 1'b1;
                head_waddr = v_reg;
                head_wdata = cnt_p1;
            end
            ST_VCLR:
            begin
                vinf_we = 1'b1;
                vinf_waddr = ptr_reg;
                vinf_wdata = '0;
            end
            ST_SINIT:
            begin
                vinf_we = 1'b1;
                vinf_waddr = s_v;
                vinf_wdata = {1'b1, {VW{1'b0}}, {EAW{1'b0}}};
                que_we = 1'b1;
                que_waddr = '0;
                que_wdata = s_v;
            end
            ST_POP:
            begin
                que_raddr = qh_reg[VW-1:0];
            end
            ST_POPW:
            begin
                head_raddr = que_rdata;
            end
            ST_EDGE:
            begin
                edge_raddr = e_reg[EAW-1:0];
            end
            ST_EDGEW:
            begin
                vinf_raddr = e_tgt;
            end
            ST_VIS:
            begin
                if (take)
                begin
                    vinf_we = 1'b1;
                    vinf_waddr = v_reg;
                    vinf_wdata = {1'b1, u_reg, e_reg[EAW-1:0]};
                    if (v_reg != t_v)
                    begin
                        que_we = 1'b1;
                        que_waddr = qt_reg[VW-1:0];
                        que_wdata = v_reg;
                    end
                end
            end
            ST_N_RD, ST_A_RD:
            begin
                vinf_raddr = w_reg;
            end
            ST_N_RDW, ST_A_RDW:
            begin
                edge_raddr = v_pe;
            end
            ST_A_FWD:
            begin
                edge_we = 1'b1;
                edge_waddr = pe_reg;
                edge_wdata = {e_tgt, e_cap - neck_reg, e_nxt};
                edge_raddr = pe_reg ^ EAW'(1);
            end
            ST_A_REV:
            begin
                edge_we = 1'b1;
                edge_waddr = pe_reg ^ EAW'(1);
                edge_wdata = {e_tgt, e_cap + neck_reg, e_nxt};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HCLR;
            src_reg <= mfe_pkg::SOURCE_RESET;
            snk_reg <= mfe_pkg::SINK_RESET;
            u_reg <= '0;
            v_reg <= '0;
            capin_reg <= '0;
            cnt_reg <= '0;
            drop_reg <= 1'b0;
            ptr_reg <= '0;
            qh_reg <= '0;
            qt_reg <= '0;
            e_reg <= '0;
            nxt_reg <= '0;
            ecap_reg <= '0;
            w_reg <= '0;
            pred_reg <= '0;
            pe_reg <= '0;
            neck_reg <= '0;
            total_reg <= '0;
            out_valid_reg <= 1'b0;
            flow_reg <= '0;
            odrop_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    mfe_pkg::CFG_SOURCE: src_reg <= cfg_data;
                    mfe_pkg::CFG_SINK:   snk_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid_reg && out_ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        u_reg <= VW'(from_vertex);
                        v_reg <= VW'(to_vertex);
                        capin_reg <= CAP_BITS'(capacity);
                        unique case (mfe_pkg::kind_t'(kind))
                            mfe_pkg::KIND_ADD:
                            begin
                                if (from_ok && to_ok)
                                begin
                                    if (store_full)
                                    begin
                                        drop_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        state_reg <= ST_ADD0;
                                    end
                                end
                            end
                            mfe_pkg::KIND_RUN:
                            begin
                                state_reg <= ST_RCHK;
                            end
                            mfe_pkg::KIND_CLEAR:
                            begin
                                cnt_reg <= '0;
                                drop_reg <= 1'b0;
                                ptr_reg <= '0;
                                state_reg <= ST_HCLR;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_HCLR:
                begin
                    ptr_reg <= ptr_reg + VW'(1);
                    if (32'(ptr_reg) == VERTICES - 1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_ADD0:
                begin
                    state_reg <= ST_ADD1;
                end
                ST_ADD1:
                begin
                    state_reg <= ST_ADD2;
                end
                ST_ADD2:
                begin
                    cnt_reg <= cnt_reg + EW'(2);
                    state_reg <= ST_IDLE;
                end
                ST_RCHK:
                begin
                    total_reg <= '0;
                    ptr_reg <= '0;
                    if ((32'(src_reg) >= 32'(VERTICES)) || (32'(snk_reg) >= 32'(VERTICES))
                        || (src_reg == snk_reg))
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_VCLR;
                    end
                end
                ST_VCLR:
                begin
                    ptr_reg <= ptr_reg + VW'(1);
                    if (32'(ptr_reg) == VERTICES - 1)
                    begin
                        state_reg <= ST_SINIT;
                    end
                end
                ST_SINIT:
                begin
                    qh_reg <= '0;
                    qt_reg <= (VW+1)'(1);
                    state_reg <= ST_POP;
                end
                ST_POP:
                begin
                    if (qh_reg == qt_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        qh_reg <= qh_reg + (VW+1)'(1);
                        state_reg <= ST_POPW;
                    end
                end
                ST_POPW:
                begin
                    u_reg <= que_rdata;
                    state_reg <= ST_HEADW;
                end
                ST_HEADW:
                begin
                    e_reg <= head_rdata;
                    state_reg <= ST_EDGE;
                end
                ST_EDGE:
                begin
                    if (e_reg[EW-1])
                    begin
                        state_reg <= ST_POP;
                    end
                    else
                    begin
                        state_reg <= ST_EDGEW;
                    end
                end
                ST_EDGEW:
                begin
                    v_reg <= e_tgt;
                    ecap_reg <= e_cap;
                    nxt_reg <= e_nxt;
                    state_reg <= ST_VIS;
                end
                ST_VIS:
                begin
                    e_reg <= nxt_reg;
                    state_reg <= ST_EDGE;
                    if (take)
                    begin
                        if (v_reg == t_v)
                        begin
                            neck_reg <= '1;
                            w_reg <= t_v;
                            state_reg <= ST_N_RD;
                        end
                        else
                        begin
                            qt_reg <= qt_reg + (VW+1)'(1);
                        end
                    end
                end
                ST_N_RD:
                begin
                    if (w_reg == s_v)
                    begin
                        w_reg <= t_v;
                        state_reg <= ST_A_RD;
                    end
                    else
                    begin
                        state_reg <= ST_N_RDW;
                    end
                end
                ST_N_RDW:
                begin
                    pred_reg <= v_pred;
                    state_reg <= ST_N_CAP;
                end
                ST_N_CAP:
                begin
                    if (e_cap < neck_reg)
                    begin
                        neck_reg <= e_cap;
                    end
                    w_reg <= pred_reg;
                    state_reg <= ST_N_RD;
                end
                ST_A_RD:
                begin
                    if (w_reg == s_v)
                    begin
                        if (sum > SW'(mfe_pkg::FLOW_MAX))
                        begin
                            total_reg <= mfe_pkg::FLOW_MAX;
                        end
                        else
                        begin
                            total_reg <= FB'(sum);
                        end
                        ptr_reg <= '0;
                        state_reg <= ST_VCLR;
                    end
                    else
                    begin
                        state_reg <= ST_A_RDW;
                    end
                end
                ST_A_RDW:
                begin
                    pred_reg <= v_pred;
                    pe_reg <= v_pe;
                    state_reg <= ST_A_FWD;
                end
                ST_A_FWD:
                begin
                    state_reg <= ST_A_REV;
                end
                ST_A_REV:
                begin
                    w_reg <= pred_reg;
                    state_reg <= ST_A_RD;
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        flow_reg <= total_reg;
                        odrop_reg <= drop_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= RES)
        else $error("residual entry count exceeds the edge store");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(qt_reg) <= VERTICES) && (qh_reg <= qt_reg))
        else $error("search queue pointers out of order");

    a_neck_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_FWD) |-> (neck_reg != '0) && (e_cap >= neck_reg))
        else $error("augmentation exceeds residual capacity");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (kind == mfe_pkg::KIND_RUN)) |=> !in_ready)
        else $error("engine ready right after taking a run transaction");

endmodule

[hdl/max_flow_shortest_path_engine.sv]
// Top level of the max-flow engine: sequencer plus edge, list head, vertex and queue RAMs.
// Depends on mfe_pkg, mfe_ram and mfe_ctrl.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    kind, from_vertex, to_vertex, capacity
//   result    out        out_valid / out_ready  flow_value, edges_dropped
//   config    in         cfg_write              cfg_index, cfg_data
//
// An add transaction passes through the accepting cycle, a list head read, then one edge
// RAM write per entry; an add that is dropped or ignored ends in the accepting cycle.
// A clear transaction, and reset, sweep every entry of the list head RAM.
// A run clears the visited flag of every vertex before each search, then pops vertices
// and scans their residual entries, and augments each path found vertex by vertex.
// The edge RAM has a single read port. A run result waits in the output register,
// and a following run stalls until that result is taken.
module max_flow_shortest_path_engine #(
    parameter int VERTICES = 256,
    parameter int EDGES = 1024,
    parameter int CAP_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    kind,
    input  logic [7:0]                    from_vertex,
    input  logic [7:0]                    to_vertex,
    input  logic [15:0]                   capacity,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mfe_pkg::FLOW_BITS-1:0] flow_value,
    output logic                          edges_dropped
);

    localparam int VW = $clog2(VERTICES);
    localparam int EAW = $clog2(2 * EDGES);
    localparam int EW = EAW + 1;
    localparam int EWD = VW + CAP_BITS + EW;
    localparam int VIW = 1 + VW + EAW;

    logic           head_we;
    logic [VW-1:0]  head_waddr;
    logic [EW-1:0]  head_wdata;
    logic [VW-1:0]  head_raddr;
    logic [EW-1:0]  head_rdata;
    logic           edge_we;
    logic [EAW-1:0] edge_waddr;
    logic [EWD-1:0] edge_wdata;
    logic [EAW-1:0] edge_raddr;
    logic [EWD-1:0] edge_rdata;
    logic           vinf_we;
    logic [VW-1:0]  vinf_waddr;
    logic [VIW-1:0] vinf_wdata;
    logic [VW-1:0]  vinf_raddr;
    logic [VIW-1:0] vinf_rdata;
    logic           que_we;
    logic [VW-1:0]  que_waddr;
    logic [VW-1:0]  que_wdata;
    logic [VW-1:0]  que_raddr;
    logic [VW-1:0]  que_rdata;

    mfe_ctrl #(
        .VERTICES (VERTICES),
        .EDGES    (EDGES),
        .CAP_BITS (CAP_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .from_vertex   (from_vertex),
        .to_vertex     (to_vertex),
        .capacity      (capacity),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .flow_value    (flow_value),
        .edges_dropped (edges_dropped),
        .head_we       (head_we),
        .head_waddr    (head_waddr),
        .head_wdata    (head_wdata),
        .head_raddr    (head_raddr),
        .head_rdata    (head_rdata),
        .edge_we       (edge_we),
        .edge_waddr    (edge_waddr),
        .edge_wdata    (edge_wdata),
        .edge_raddr    (edge_raddr),
        .edge_rdata    (edge_rdata),
        .vinf_we       (vinf_we),
        .vinf_waddr    (vinf_waddr),
        .vinf_wdata    (vinf_wdata),
        .vinf_raddr    (vinf_raddr),
        .vinf_rdata    (vinf_rdata),
        .que_we        (que_we),
        .que_waddr     (que_waddr),
        .que_wdata     (que_wdata),
        .que_raddr     (que_raddr),
        .que_rdata     (que_rdata)
    );

    mfe_ram #(.DEPTH(VERTICES), .WIDTH(EW)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    mfe_ram #(.DEPTH(2 * EDGES), .WIDTH(EWD)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    mfe_ram #(.DEPTH(VERTICES), .WIDTH(VIW)) u_vinf_ram (
        .clk   (clk),
        .we    (vinf_we),
        .waddr (vinf_waddr),
        .wdata (vinf_wdata),
        .raddr (vinf_raddr),
        .rdata (vinf_rdata)
    );

    mfe_ram #(.DEPTH(VERTICES), .WIDTH(VW)) u_que_ram (
        .clk   (clk),
        .we    (que_we),
        .waddr (que_waddr),
        .wdata (que_wdata),
        .raddr (que_raddr),
        .rdata (que_rdata)
    );

endmodule
